// ----- sv/gpr_pkg.sv -----
// Shared types and constants for the GPIO port register block with pin lock.
// Used by every module of the block; depends on nothing.
`default_nettype none

package gpr_pkg;

    localparam int unsigned PinCountDefault = 16;
    localparam int unsigned PinMax          = 16;
    localparam int unsigned NibblesPerReg   = 8;

    localparam logic [31:0] CfgReset   = 32'h4444_4444;
    localparam logic [3:0]  NibbleMask = 4'hF;
    localparam int unsigned LockKeyBit = 16;

    localparam logic [2:0] SelCfgLow   = 3'd0;
    localparam logic [2:0] SelCfgHigh  = 3'd1;
    localparam logic [2:0] SelInData   = 3'd2;
    localparam logic [2:0] SelOutData  = 3'd3;
    localparam logic [2:0] SelSetReset = 3'd4;
    localparam logic [2:0] SelReset    = 3'd5;
    localparam logic [2:0] SelLock     = 3'd6;

    localparam logic ReqRead  = 1'b0;
    localparam logic ReqWrite = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  reg_select;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } access_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] out_levels;
        logic [31:0] pin_config_low;
        logic [31:0] pin_config_high;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/gpr_in_stage.sv -----
// Input register for bus accesses of the GPIO port block.
// Depends on gpr_pkg for the access structure.
`default_nettype none

module gpr_in_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire gpr_pkg::access_t in_item,
    output logic                  item_valid,
    output gpr_pkg::access_t      item,
    input  wire logic             advance
);

    logic             valid_reg;
    gpr_pkg::access_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/gpr_core.sv -----
// Port state (config, output data, lock sequence) and the access decode.
// Updates state when an access advances and forms its result. Depends on gpr_pkg.
`default_nettype none

module gpr_core #(
    parameter int unsigned PIN_COUNT = gpr_pkg::PinCountDefault
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire gpr_pkg::access_t item,
    output gpr_pkg::result_t      result
);

    localparam logic [15:0] PinMask = 16'((33'd1 << PIN_COUNT) - 33'd1);

    typedef enum logic [1:0] {
        LOCK_IDLE,
        LOCK_KEY1,
        LOCK_KEY2
    } lock_step_t;

    logic [31:0] cfg_low_reg, cfg_low_next;
    logic [31:0] cfg_high_reg, cfg_high_next;
    logic [15:0] out_data_reg, out_data_next;
    logic [15:0] locked_pins_reg, locked_pins_next;
    logic        key_active_reg, key_active_next;
    lock_step_t  lock_step_reg, lock_step_next;
    logic [15:0] pending_pins_reg, pending_pins_next;

    logic [15:0] frozen;
    logic [31:0] keep_low;
    logic [31:0] keep_high;
    logic [15:0] lock_pins;
    logic        lock_key;
    logic [31:0] read_value;
    logic        is_write;

    assign frozen    = locked_pins_reg | ~PinMask;
    assign lock_pins = item.write_data[15:0] & PinMask;
    assign lock_key  = item.write_data[gpr_pkg::LockKeyBit];
    assign is_write  = (item.req_type == gpr_pkg::ReqWrite);

    always_comb begin
        for (int i = 0; i < gpr_pkg::NibblesPerReg; i++) begin
            keep_low[4*i +: 4]  = frozen[i] ? gpr_pkg::NibbleMask : 4'h0;
            keep_high[4*i +: 4] = frozen[i + gpr_pkg::NibblesPerReg] ?
                                  gpr_pkg::NibbleMask : 4'h0;
        end
    end

    always_comb begin
        cfg_low_next      = cfg_low_reg;
        cfg_high_next     = cfg_high_reg;
        out_data_next     = out_data_reg;
        locked_pins_next  = locked_pins_reg;
        key_active_next   = key_active_reg;
        lock_step_next    = lock_step_reg;
        pending_pins_next = pending_pins_reg;
        if (is_write) begin
            unique case (item.reg_select)
                gpr_pkg::SelCfgLow: begin
                    cfg_low_next = (cfg_low_reg & keep_low) | (item.write_data & ~keep_low);
                end
                gpr_pkg::SelCfgHigh: begin
                    cfg_high_next = (cfg_high_reg & keep_high)
                                  | (item.write_data & ~keep_high);
                end
                gpr_pkg::SelOutData: begin
                    out_data_next = item.write_data[15:0] & PinMask;
                end
                gpr_pkg::SelSetReset: begin
                    out_data_next = ((out_data_reg & ~item.write_data[31:16])
                                  | item.write_data[15:0]) & PinMask;
                end
                gpr_pkg::SelReset: begin
                    out_data_next = out_data_reg & ~item.write_data[15:0] & PinMask;
                end
                gpr_pkg::SelLock: begin
                    if (!key_active_reg) begin
                        priority if (lock_step_reg == LOCK_KEY1 && !lock_key
                                     && lock_pins == pending_pins_reg) begin
                            lock_step_next = LOCK_KEY2;
                        end else if (lock_step_reg == LOCK_KEY2 && lock_key
                                     && lock_pins == pending_pins_reg) begin
                            key_active_next  = 1'b1;
                            locked_pins_next = lock_pins;
                            lock_step_next   = LOCK_IDLE;
                        end else if (lock_key) begin
                            pending_pins_next = lock_pins;
                            lock_step_next    = LOCK_KEY1;
                        end else begin
                            lock_step_next = LOCK_IDLE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (item.reg_select)
            gpr_pkg::SelCfgLow:  read_value = cfg_low_reg;
            gpr_pkg::SelCfgHigh: read_value = cfg_high_reg;
            gpr_pkg::SelInData:  read_value = {16'h0, item.pin_levels & PinMask};
            gpr_pkg::SelOutData: read_value = {16'h0, out_data_reg};
            gpr_pkg::SelLock:    read_value = {15'h0, key_active_reg, locked_pins_reg};
            default:             read_value = 32'h0;
        endcase
    end

    always_comb begin
        result.read_data       = is_write ? 32'h0 : read_value;
        result.out_levels      = out_data_next;
        result.pin_config_low  = cfg_low_next;
        result.pin_config_high = cfg_high_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_low_reg      <= gpr_pkg::CfgReset;
            cfg_high_reg     <= gpr_pkg::CfgReset;
            out_data_reg     <= 16'h0;
            locked_pins_reg  <= 16'h0;
            key_active_reg   <= 1'b0;
            lock_step_reg    <= LOCK_IDLE;
            pending_pins_reg <= 16'h0;
        end else if (advance) begin
            cfg_low_reg      <= cfg_low_next;
            cfg_high_reg     <= cfg_high_next;
            out_data_reg     <= out_data_next;
            locked_pins_reg  <= locked_pins_next;
            key_active_reg   <= key_active_next;
            lock_step_reg    <= lock_step_next;
            pending_pins_reg <= pending_pins_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/gpr_out_stage.sv -----
// Result register of the GPIO port block, held until the receiver takes it.
// Depends on gpr_pkg for the result structure.
`default_nettype none

module gpr_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    output logic                  can_load,
    input  wire gpr_pkg::result_t load_result,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output gpr_pkg::result_t      out_result
);

    logic             valid_reg;
    gpr_pkg::result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

endmodule

`default_nettype wire

// ----- sv/gpio_port_registers_with_lock_top.sv -----
// Top level of the 16-pin GPIO port register block with configuration lock.
// Depends on gpr_pkg, gpr_in_stage, gpr_core and gpr_out_stage.
//
// Each slave-side transfer is one register access; each produces exactly one
// master-side transfer carrying the read value and the port state after it.
// The access is first captured in an input register, then decoded and applied
// to the port state as it moves into the result register, from which it is
// offered on the master side.
// One access per cycle is sustained while the receiver takes results; the only
// loop is the state update between two accesses.
// When the receiver stalls, the result register holds its transfer and the
// input register keeps one more access, after which s_tready goes low.
// A synchronous low on aresetn empties both registers, restores the config
// registers to floating inputs, clears the output data and abandons any lock
// sequence; a completed lock stays in force until reset.
// PIN_COUNT limits which pins exist; absent pins keep their reset values.
`default_nettype none

module gpio_port_registers_with_lock_top #(
    parameter int unsigned PIN_COUNT = gpr_pkg::PinCountDefault
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,  // write_data[31:0], pin_levels[47:32]
    input  wire logic [3:0]   s_tuser,  // req_type[0], reg_select[3:1]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata   // read_data[31:0], out_levels[47:32],
                                        // pin_config_low[79:48],
                                        // pin_config_high[111:80]
);

    gpr_pkg::access_t in_item;
    gpr_pkg::access_t item;
    gpr_pkg::result_t result;
    gpr_pkg::result_t out_result;
    logic             item_valid;
    logic             can_load;
    logic             advance;

    assign in_item.req_type   = s_tuser[0];
    assign in_item.reg_select = s_tuser[3:1];
    assign in_item.write_data = s_tdata[31:0];
    assign in_item.pin_levels = s_tdata[47:32];

    assign advance = item_valid && can_load;

    gpr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance)
    );

    gpr_core #(
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    gpr_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance),
        .can_load    (can_load),
        .load_result (result),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

    assign m_tdata = {out_result.pin_config_high, out_result.pin_config_low,
                      out_result.out_levels, out_result.read_data};

endmodule

`default_nettype wire

// ----- sim/gpio_port_registers_with_lock_top_test.sv -----
// Self-checking testbench for the GPIO port register block with configuration lock.
// It predicts every result transfer and checks each field against the port state it expects.
// Depends on gpr_pkg and gpio_port_registers_with_lock_top.
module gpio_port_registers_with_lock_top_test;

    localparam logic [2:0] SelUnused = 3'd7;
    localparam logic [1:0] KeyIdle = 2'd0;
    localparam logic [1:0] KeyFirstSeen = 2'd1;
    localparam logic [1:0] KeySecondSeen = 2'd2;
    localparam int AccessTotal = 1650;
    localparam int StallLimit = 2000;
    localparam int LongHoldCycles = 80;
    localparam int QuietTail = 150;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic [3:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [111:0] m_tdata;

    gpio_port_registers_with_lock_top dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    gpr_pkg::access_t access_queue[$];
    gpr_pkg::result_t port_views_due[$];
    gpr_pkg::access_t on_bus;
    int accesses_queued = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    bit fill_done = 1'b0;
    bit mid_drain_done = 1'b0;

    logic [31:0] cfg_low = gpr_pkg::CfgReset;
    logic [31:0] cfg_high = gpr_pkg::CfgReset;
    logic [15:0] out_reg = '0;
    logic [15:0] locked_pins = '0;
    logic lock_active = 1'b0;
    logic [1:0] key_step = KeyIdle;
    logic [15:0] key_pins = '0;

    function automatic logic [31:0] frozen_nibbles(input int base);
        logic [31:0] keep;
        keep = '0;
        for (int i = 0; i < 8; i++) begin
            if (locked_pins[base + i]) begin
                keep[4 * i +: 4] = gpr_pkg::NibbleMask;
            end
        end
        return keep;
    endfunction

    function automatic gpr_pkg::result_t apply_register_access(input gpr_pkg::access_t acc);
        gpr_pkg::result_t view;
        logic [31:0] keep;
        logic [15:0] pins;
        logic key;
        view.read_data = '0;
        pins = acc.write_data[15:0];
        key = acc.write_data[gpr_pkg::LockKeyBit];
        if (acc.req_type == gpr_pkg::ReqWrite) begin
            case (acc.reg_select)
                gpr_pkg::SelCfgLow: begin
                    keep = frozen_nibbles(0);
                    cfg_low = (cfg_low & keep) | (acc.write_data & ~keep);
                end
                gpr_pkg::SelCfgHigh: begin
                    keep = frozen_nibbles(8);
                    cfg_high = (cfg_high & keep) | (acc.write_data & ~keep);
                end
                gpr_pkg::SelOutData: out_reg = acc.write_data[15:0];
                gpr_pkg::SelSetReset: begin
                    out_reg = (out_reg & ~acc.write_data[31:16]) | acc.write_data[15:0];
                end
                gpr_pkg::SelReset: out_reg = out_reg & ~acc.write_data[15:0];
                gpr_pkg::SelLock: begin
                    if (!lock_active) begin
                        if (key_step == KeyFirstSeen && !key && pins == key_pins) begin
                            key_step = KeySecondSeen;
                        end else if (key_step == KeySecondSeen && key && pins == key_pins) begin
                            lock_active = 1'b1;
                            locked_pins = pins;
                            key_step = KeyIdle;
                        end else if (key) begin
                            key_pins = pins;
                            key_step = KeyFirstSeen;
                        end else begin
                            key_step = KeyIdle;
                        end
                    end
                end
                default: ;
            endcase
        end else begin
            case (acc.reg_select)
                gpr_pkg::SelCfgLow: view.read_data = cfg_low;
                gpr_pkg::SelCfgHigh: view.read_data = cfg_high;
                gpr_pkg::SelInData: view.read_data = {16'h0, acc.pin_levels};
                gpr_pkg::SelOutData: view.read_data = {16'h0, out_reg};
                gpr_pkg::SelLock: view.read_data = {15'h0, lock_active, locked_pins};
                default: view.read_data = '0;
            endcase
        end
        view.out_levels = out_reg;
        view.pin_config_low = cfg_low;
        view.pin_config_high = cfg_high;
        return view;
    endfunction

    function automatic bit idling_allowed();
        return !(fill_done && access_queue.size() < QuietTail);
    endfunction

    // Sender side.
    int tx_gap = 0;
    int tx_chance = 2;
    logic rx_holding = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                port_views_due.push_back(apply_register_access(on_bus));
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0 && !rx_holding) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (access_queue.size() > 0) begin
                    on_bus = access_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {on_bus.pin_levels, on_bus.write_data};
                    s_tuser <= {on_bus.reg_select, on_bus.req_type};
                    if (idling_allowed() && tx_chance != 0
                        && $urandom_range(0, tx_chance) == 0) begin
                        tx_gap = $urandom_range(1, 12);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
                if ($urandom_range(0, 199) == 0) begin
                    tx_chance = $urandom_range(0, 4);
                end
            end
        end
    end

    // Receiver side.
    int rx_gap = 0;
    int rx_chance = 2;
    int hold_left = 0;
    bit hold_done = 1'b0;

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        gpr_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (port_views_due.size() == 0) begin
                    $error("result transfer with no access outstanding: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = port_views_due.pop_front();
                    check_field("read_data", want.read_data, m_tdata[31:0]);
                    check_field("out_levels", {16'h0, want.out_levels}, {16'h0, m_tdata[47:32]});
                    check_field("pin_config_low", want.pin_config_low, m_tdata[79:48]);
                    check_field("pin_config_high", want.pin_config_high, m_tdata[111:80]);
                end
                results_checked++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
                rx_holding <= (hold_left > 0);
            end else if (!hold_done && results_checked >= 400) begin
                hold_done = 1'b1;
                hold_left = LongHoldCycles;
                m_tready <= 1'b0;
                rx_holding <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idling_allowed() && rx_chance != 0 && $urandom_range(0, rx_chance) == 0) begin
                    rx_gap = $urandom_range(1, 12);
                end
            end
            if ($urandom_range(0, 199) == 0) begin
                rx_chance = $urandom_range(0, 4);
            end
        end
    end

    int stall_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn && !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            stall_cycles++;
            if (stall_cycles >= StallLimit) begin
                $display("gpio_port_registers_with_lock_top_test failed");
                $finish;
            end
        end else begin
            stall_cycles = 0;
        end
    end

    function automatic gpr_pkg::access_t make_access(input logic req, input logic [2:0] sel,
                                                     input logic [31:0] data,
                                                     input logic [15:0] levels);
        gpr_pkg::access_t acc;
        acc.req_type = req;
        acc.reg_select = sel;
        acc.write_data = data;
        acc.pin_levels = levels;
        return acc;
    endfunction

    function automatic gpr_pkg::access_t random_access(input bit lock_writes_ok);
        gpr_pkg::access_t acc;
        acc.req_type = 1'($urandom_range(0, 1));
        acc.reg_select = 3'($urandom_range(0, 7));
        if (!lock_writes_ok && acc.req_type == gpr_pkg::ReqWrite
            && acc.reg_select == gpr_pkg::SelLock) begin
            acc.req_type = gpr_pkg::ReqRead;
        end
        case ($urandom_range(0, 7))
            0: acc.write_data = '0;
            1: acc.write_data = '1;
            default: acc.write_data = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0: acc.pin_levels = '0;
            1: acc.pin_levels = '1;
            default: acc.pin_levels = 16'($urandom_range(0, 65535));
        endcase
        return acc;
    endfunction

    task automatic push_access(input gpr_pkg::access_t acc);
        access_queue.push_back(acc);
        accesses_queued++;
    endtask

    task automatic push_lock_sequence(input bit intact);
        logic [15:0] pins;
        logic [15:0] step_pins;
        logic [31:0] data;
        logic key;
        int bad_step;
        pins = 16'($urandom_range(0, 65535));
        bad_step = intact ? -1 : int'($urandom_range(0, 2));
        for (int step = 0; step < 3; step++) begin
            key = (step != 1);
            step_pins = pins;
            if (step == bad_step) begin
                if ($urandom_range(0, 1) == 0) begin
                    key = !key;
                end else begin
                    step_pins = pins ^ (16'h1 << $urandom_range(0, 15));
                end
            end
            data = $urandom;
            data[gpr_pkg::LockKeyBit] = key;
            data[15:0] = step_pins;
            push_access(make_access(gpr_pkg::ReqWrite, gpr_pkg::SelLock, data,
                                    16'($urandom_range(0, 65535))));
            repeat ($urandom_range(0, 2)) push_access(random_access(1'b0));
        end
    endtask

    task automatic wait_for_drain();
        while (access_queue.size() != 0 || s_tvalid || port_views_due.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        push_access(make_access(gpr_pkg::ReqRead, gpr_pkg::SelCfgLow, '0, '0));
        push_access(make_access(gpr_pkg::ReqRead, gpr_pkg::SelCfgHigh, '1, '1));
        push_access(make_access(gpr_pkg::ReqRead, gpr_pkg::SelInData, '0, 16'hFFFF));
        push_access(make_access(gpr_pkg::ReqRead, gpr_pkg::SelInData, '1, 16'h0000));
        push_access(make_access(gpr_pkg::ReqRead, gpr_pkg::SelOutData, '0, '0));
        push_access(make_access(gpr_pkg::ReqRead, gpr_pkg::SelSetReset, '1, '1));
        push_access(make_access(gpr_pkg::ReqRead, gpr_pkg::SelReset, '1, '1));
        push_access(make_access(gpr_pkg::ReqRead, SelUnused, '1, '1));
        push_access(make_access(gpr_pkg::ReqRead, gpr_pkg::SelLock, '0, '0));
        push_access(make_access(gpr_pkg::ReqWrite, gpr_pkg::SelCfgLow, 32'hFFFF_FFFF, '0));
        push_access(make_access(gpr_pkg::ReqWrite, gpr_pkg::SelCfgHigh, 32'h0000_0000, '0));
        push_access(make_access(gpr_pkg::ReqWrite, gpr_pkg::SelInData, 32'hFFFF_FFFF,
                                16'hFFFF));
        push_access(make_access(gpr_pkg::ReqWrite, gpr_pkg::SelOutData, 32'hFFFF_FFFF, '0));
        push_access(make_access(gpr_pkg::ReqWrite, gpr_pkg::SelReset, 32'h0000_00FF, '0));
        push_access(make_access(gpr_pkg::ReqWrite, gpr_pkg::SelSetReset, 32'hFFFF_0000, '0));
        // Set and reset requested together on bits 7:4: set must win.
        push_access(make_access(gpr_pkg::ReqWrite, gpr_pkg::SelSetReset, 32'hFFFF_00F0, '0));
        push_access(make_access(gpr_pkg::ReqWrite, SelUnused, 32'hFFFF_FFFF, '0));
        // A key sequence that never completes: bad opening, restart, then a wrong third step.
        push_access(make_access(gpr_pkg::ReqWrite, gpr_pkg::SelLock, 32'h0000_00A5, '0));
        push_access(make_access(gpr_pkg::ReqWrite, gpr_pkg::SelLock, 32'hFFFF_00A5, '0));
        push_access(make_access(gpr_pkg::ReqRead, gpr_pkg::SelLock, '0, '0));
        push_access(make_access(gpr_pkg::ReqWrite, gpr_pkg::SelLock, 32'h0001_5A5A, '0));
        push_access(make_access(gpr_pkg::ReqWrite, gpr_pkg::SelLock, 32'h0000_5A5A, '0));
        push_access(make_access(gpr_pkg::ReqWrite, gpr_pkg::SelLock, 32'h0000_5A5A, '0));
        push_access(make_access(gpr_pkg::ReqRead, gpr_pkg::SelCfgLow, '0, '0));
        wait_for_drain();

        while (accesses_queued < AccessTotal) begin
            if (!mid_drain_done && accesses_queued >= AccessTotal / 2) begin
                mid_drain_done = 1'b1;
                wait_for_drain();
            end
            if ($urandom_range(0, 14) == 0) begin
                push_lock_sequence(accesses_queued >= 1000);
            end else begin
                push_access(random_access(1'b1));
            end
        end
        fill_done = 1'b1;

        wait_for_drain();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("gpio_port_registers_with_lock_top_test passed");
        end else begin
            $display("gpio_port_registers_with_lock_top_test failed");
        end
        $finish;
    end
endmodule
